@@ sv/hrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrr_pkg
// Shared constants, word types and helper functions for the holding-register
// read responder.
// ----------------------------------------------------------------------------
package hrr_pkg;

    // Table geometry and request limits.
    localparam int TABLE_DEPTH   = 64;
    localparam int TABLE_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_REGS      = 29;
    localparam int CNT_W         = $clog2(MAX_REGS + 1);
    localparam int PRELOAD_COUNT = 50;

    // CRC-16 parameters (reflected form).
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Operation codes of a request word.
    localparam logic OP_READ = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Request word.
    typedef struct packed {
        logic        op;
        logic [7:0]  slave_addr;
        logic [7:0]  func_code;
        logic [15:0] start_addr;
        logic [15:0] reg_count;
        logic [5:0]  load_index;
        logic [15:0] load_value;
    } req_word_t;

    // Response word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       range_error;
    } rsp_word_t;

    // Access request from the framer to the register table.
    typedef struct packed {
        logic                wr_en;
        logic [TABLE_AW-1:0] wr_addr;
        logic [15:0]         wr_data;
        logic                rd_en;
        logic [TABLE_AW-1:0] rd_addr;
    } tbl_req_t;

    // Reset contents of the register table.
    function automatic logic [15:0] hrr_preload(input logic [TABLE_AW-1:0] idx);
        logic [15:0] val;
        val = 16'd0;
        case (int'(idx))
            0:  val = 16'd0;
            1:  val = 16'd1111;
            2:  val = 16'd2222;
            3:  val = 16'd3333;
            4:  val = 16'd4444;
            5:  val = 16'd5555;
            6:  val = 16'd6666;
            7:  val = 16'd7777;
            8:  val = 16'd8888;
            9:  val = 16'd9999;
            10: val = 16'd12345;
            11: val = 16'd15432;
            12: val = 16'd15535;
            13: val = 16'd10234;
            14: val = 16'd19876;
            15: val = 16'd13579;
            16: val = 16'd10293;
            17: val = 16'd19827;
            18: val = 16'd13456;
            19: val = 16'd14567;
            20: val = 16'd21345;
            21: val = 16'd22345;
            22: val = 16'd24567;
            23: val = 16'd25678;
            24: val = 16'd26789;
            25: val = 16'd24680;
            26: val = 16'd20394;
            27: val = 16'd29384;
            28: val = 16'd26937;
            29: val = 16'd27654;
            30: val = 16'd31245;
            31: val = 16'd31456;
            32: val = 16'd34567;
            33: val = 16'd35678;
            34: val = 16'd36789;
            35: val = 16'd37890;
            36: val = 16'd30948;
            37: val = 16'd34958;
            38: val = 16'd35867;
            39: val = 16'd36092;
            40: val = 16'd45678;
            41: val = 16'd46789;
            42: val = 16'd47890;
            43: val = 16'd41235;
            44: val = 16'd42356;
            45: val = 16'd43567;
            46: val = 16'd40596;
            47: val = 16'd49586;
            48: val = 16'd48765;
            49: val = 16'd41029;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

    // Fold one byte into the running CRC, one bit per step.
    function automatic logic [15:0] hrr_crc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ sv/hrr_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrr_table
// Holding-register storage: a synchronous memory with its own write port and a
// registered read and per-entry written flags that stand in for the preload.
// ----------------------------------------------------------------------------
module hrr_table
    import hrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tbl_req_t    req,
    output logic [15:0] rd_data
);

    logic [15:0]         mem_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] written_reg;
    logic [15:0]         rd_q_reg;
    logic                rd_written_reg;
    logic [TABLE_AW-1:0] rd_addr_reg;

    // Memory write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg    <= mem_reg[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    // Written flags: an entry never written reads as its preload value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    // Select the stored word or the preload value.
    assign rd_data = rd_written_reg ? rd_q_reg : hrr_preload(rd_addr_reg);

endmodule

@@ sv/hrr_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrr_framer
// Request sequencer: applies table loads, checks read ranges and walks the
// response frame byte by byte while accumulating the CRC.
// ----------------------------------------------------------------------------
module hrr_framer
    import hrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_word_t   req_word,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_word_t   rsp_word,
    output tbl_req_t    tbl_req,
    input  logic [15:0] tbl_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_SLAVE,
        S_FUNC,
        S_BCNT,
        S_HI,
        S_LO,
        S_CRCL,
        S_CRCH
    } state_t;

    state_t              state_reg, state_next;
    logic [7:0]          slave_reg, slave_next;
    logic [7:0]          func_reg, func_next;
    logic [TABLE_AW-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic [15:0]         crc_reg, crc_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_word_reg, rsp_word_next;

    logic       accept;
    logic       can_emit;
    logic       do_emit;
    logic       emit_data;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       emit_err;
    logic       bad_range;
    logic [16:0] range_end;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign can_emit  = !rsp_valid_reg || rsp_ready;

    // Range check of a read request.
    assign range_end = {1'b0, req_word.start_addr} + {1'b0, req_word.reg_count};
    assign bad_range = (req_word.reg_count == 16'd0)
                    || (32'(req_word.reg_count) > MAX_REGS)
                    || (32'(range_end) > TABLE_DEPTH);

    // Next-state and frame byte selection.
    always_comb
    begin
        state_next  = state_reg;
        slave_next  = slave_reg;
        func_next   = func_reg;
        addr_next   = addr_reg;
        remain_next = remain_reg;
        crc_next    = crc_reg;
        do_emit     = 1'b0;
        emit_data   = 1'b0;
        emit_byte   = 8'd0;
        emit_last   = 1'b0;
        emit_err    = 1'b0;
        tbl_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_word.op == OP_LOAD)
                    begin
                        tbl_req.wr_en   = (32'(req_word.load_index) < TABLE_DEPTH);
                        tbl_req.wr_addr = TABLE_AW'(req_word.load_index);
                        tbl_req.wr_data = req_word.load_value;
                    end
                    else
                    begin
                        slave_next  = req_word.slave_addr;
                        func_next   = req_word.func_code;
                        addr_next   = req_word.start_addr[TABLE_AW-1:0];
                        remain_next = req_word.reg_count[CNT_W-1:0];
                        crc_next    = CRC_INIT;
                        state_next  = bad_range ? S_ERR : S_SLAVE;
                    end
                end
            end
            S_ERR:
            begin
                if (can_emit)
                begin
                    do_emit    = 1'b1;
                    emit_last  = 1'b1;
                    emit_err   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SLAVE:
            begin
                if (can_emit)
                begin
                    do_emit    = 1'b1;
                    emit_data  = 1'b1;
                    emit_byte  = slave_reg;
                    state_next = S_FUNC;
                end
            end
            S_FUNC:
            begin
                if (can_emit)
                begin
                    do_emit    = 1'b1;
                    emit_data  = 1'b1;
                    emit_byte  = func_reg;
                    state_next = S_BCNT;
                end
            end
            S_BCNT:
            begin
                if (can_emit)
                begin
                    do_emit        = 1'b1;
                    emit_data      = 1'b1;
                    emit_byte      = 8'({remain_reg, 1'b0});
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = addr_reg;
                    state_next     = S_HI;
                end
            end
            S_HI:
            begin
                if (can_emit)
                begin
                    do_emit    = 1'b1;
                    emit_data  = 1'b1;
                    emit_byte  = tbl_rd_data[15:8];
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                if (can_emit)
                begin
                    do_emit     = 1'b1;
                    emit_data   = 1'b1;
                    emit_byte   = tbl_rd_data[7:0];
                    addr_next   = addr_reg + TABLE_AW'(1);
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_CRCL;
                    end
                    else
                    begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = addr_reg + TABLE_AW'(1);
                        state_next     = S_HI;
                    end
                end
            end
            S_CRCL:
            begin
                if (can_emit)
                begin
                    do_emit    = 1'b1;
                    emit_byte  = crc_reg[7:0];
                    state_next = S_CRCH;
                end
            end
            S_CRCH:
            begin
                if (can_emit)
                begin
                    do_emit    = 1'b1;
                    emit_byte  = crc_reg[15:8];
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Fold each frame data byte into the CRC as it leaves.
        if (emit_data)
        begin
            crc_next = hrr_crc_byte(crc_reg, emit_byte);
        end

        // Output register: load a new word or drop the one just taken.
        rsp_word_next = rsp_word_reg;
        if (do_emit)
        begin
            rsp_valid_next            = 1'b1;
            rsp_word_next.out_byte    = emit_byte;
            rsp_word_next.last        = emit_last;
            rsp_word_next.range_error = emit_err;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slave_reg     <= '0;
            func_reg      <= '0;
            addr_reg      <= '0;
            remain_reg    <= '0;
            crc_reg       <= CRC_INIT;
            rsp_valid_reg <= 1'b0;
            rsp_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            slave_reg     <= slave_next;
            func_reg      <= func_next;
            addr_reg      <= addr_next;
            remain_reg    <= remain_next;
            crc_reg       <= crc_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_word_reg  <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

@@ sv/holding_register_read_responder.sv @@
`timescale 1ns / 1ps
// A read's first byte passes the state register, then the output register.
// A frame is slave, function, byte count, high and low bytes per register
// and two CRC bytes; a range error is one word. The sequencer handles one
// request at a time; one byte leaves per cycle while rsp_ready is held high.
// Reset clears the sequencer and restores the preload table contents at once.
// ----------------------------------------------------------------------------
// holding_register_read_responder
// Answers read-holding-register requests from a 64-word table with a framed,
// CRC-protected byte stream; load words update the table.
// ----------------------------------------------------------------------------
module holding_register_read_responder
    import hrr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp_word
);

    tbl_req_t    tbl_req;
    logic [15:0] tbl_rd_data;

    // Frame sequencer.
    hrr_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_word    (req_word),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_word    (rsp_word),
        .tbl_req     (tbl_req),
        .tbl_rd_data (tbl_rd_data)
    );

    // Register table.
    hrr_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

endmodule

@@ sv/hrr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrr_checker
// Port-level checks of the response stream: stall behavior, error word form,
// frame length and the byte count field.
// ----------------------------------------------------------------------------
module hrr_checker
    import hrr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_word_t rsp_word
);

    logic [7:0] byte_cnt_reg;

    // Count the bytes of the frame in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            byte_cnt_reg <= rsp_word.last ? 8'd0 : byte_cnt_reg + 8'd1;
        end
    end

    // A stalled word stays put.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("response word changed while stalled");

    // An error word stands alone, is zero and closes its response.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.range_error |->
            rsp_word.last && rsp_word.out_byte == 8'd0 && byte_cnt_reg == 8'd0)
        else $error("malformed range error word");

    // A good frame has an odd length of at least seven bytes.
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.last && !rsp_word.range_error |->
            byte_cnt_reg >= 8'd6 && !byte_cnt_reg[0])
        else $error("frame length is wrong");

    // The byte count field is even and nonzero.
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && byte_cnt_reg == 8'd2 |->
            !rsp_word.out_byte[0] && rsp_word.out_byte != 8'd0)
        else $error("byte count field is wrong");

endmodule

bind holding_register_read_responder hrr_checker u_hrr_checker (.*);

@@ verif/tb_holding_register_read_responder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_holding_register_read_responder
// Self-checking testbench for the holding-register read responder. Request
// words are sent with random gaps. A local model of the register table and of
// the CRC-16 frame builder predicts every response word. Response words are
// taken with random back-pressure and compared field by field in order.
// ----------------------------------------------------------------------------
module tb_holding_register_read_responder;
    import hrr_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 280;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req_word  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_word_t rsp_word;

    // Local copy of the register table and its reset contents.
    logic [15:0] table_model [TABLE_DEPTH];
    logic [15:0] preload_words [PRELOAD_COUNT] = '{
        16'd0,     16'd1111,  16'd2222,  16'd3333,  16'd4444,
        16'd5555,  16'd6666,  16'd7777,  16'd8888,  16'd9999,
        16'd12345, 16'd15432, 16'd15535, 16'd10234, 16'd19876,
        16'd13579, 16'd10293, 16'd19827, 16'd13456, 16'd14567,
        16'd21345, 16'd22345, 16'd24567, 16'd25678, 16'd26789,
        16'd24680, 16'd20394, 16'd29384, 16'd26937, 16'd27654,
        16'd31245, 16'd31456, 16'd34567, 16'd35678, 16'd36789,
        16'd37890, 16'd30948, 16'd34958, 16'd35867, 16'd36092,
        16'd45678, 16'd46789, 16'd47890, 16'd41235, 16'd42356,
        16'd43567, 16'd40596, 16'd49586, 16'd48765, 16'd41029
    };

    // Response words still owed by the block, oldest first.
    rsp_word_t pending_bytes [$];

    int error_count = 0;
    int cycle_count = 0;
    bit no_idle     = 1'b0;

    holding_register_read_responder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Cycle counter with a hard limit on the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_holding_register_read_responder failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("ERROR cycle %0d: %s expected 0x%0h got 0x%0h",
                 cycle_count, what, want, got);
        error_count++;
    endtask

    // Reflected CRC-16 update by one byte.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic is_last,
                             input logic is_err);
        rsp_word_t w;
        w.out_byte    = b;
        w.last        = is_last;
        w.range_error = is_err;
        pending_bytes.push_back(w);
    endtask

    // Apply one accepted request word to the model and queue its response.
    task automatic predict_response(input req_word_t w);
        int          first;
        int          count;
        logic [15:0] crc;
        logic [15:0] entry;
        logic [7:0]  count_byte;
        first = int'(w.start_addr);
        count = int'(w.reg_count);
        if (w.op == OP_LOAD)
        begin
            if (int'(w.load_index) < TABLE_DEPTH)
                table_model[w.load_index] = w.load_value;
        end
        else if (count == 0 || count > MAX_REGS || first + count > TABLE_DEPTH)
        begin
            push_byte(8'h00, 1'b1, 1'b1);
        end
        else
        begin
            crc        = CRC_INIT;
            count_byte = {w.reg_count[6:0], 1'b0};
            push_byte(w.slave_addr, 1'b0, 1'b0);
            crc = crc_fold(crc, w.slave_addr);
            push_byte(w.func_code, 1'b0, 1'b0);
            crc = crc_fold(crc, w.func_code);
            push_byte(count_byte, 1'b0, 1'b0);
            crc = crc_fold(crc, count_byte);
            for (int i = 0; i < count; i++)
            begin
                entry = table_model[first + i];
                push_byte(entry[15:8], 1'b0, 1'b0);
                crc = crc_fold(crc, entry[15:8]);
                push_byte(entry[7:0], 1'b0, 1'b0);
                crc = crc_fold(crc, entry[7:0]);
            end
            push_byte(crc[7:0], 1'b0, 1'b0);
            push_byte(crc[15:8], 1'b1, 1'b0);
        end
    endtask

    function automatic req_word_t read_req(input logic [7:0] slave,
                                           input logic [7:0] func,
                                           input logic [15:0] first,
                                           input logic [15:0] count);
        req_word_t w;
        w.op         = OP_READ;
        w.slave_addr = slave;
        w.func_code  = func;
        w.start_addr = first;
        w.reg_count  = count;
        w.load_index = 6'($urandom());
        w.load_value = 16'($urandom());
        return w;
    endfunction

    function automatic req_word_t load_req(input logic [5:0] idx,
                                           input logic [15:0] value);
        req_word_t w;
        w.op         = OP_LOAD;
        w.slave_addr = 8'($urandom());
        w.func_code  = 8'($urandom());
        w.start_addr = 16'($urandom());
        w.reg_count  = 16'($urandom());
        w.load_index = idx;
        w.load_value = value;
        return w;
    endfunction

    // Send one request word after a random gap and wait for its acceptance.
    task automatic send_word(input req_word_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        predict_response(w);
    endtask

    // Lower valid and wait until every owed response word has arrived.
    task automatic hold_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Response sink: random stall before each word, then ready until taken.
    initial
    begin : rsp_sink
        int stall;
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
        end
    end

    // Compare each accepted response word with the oldest owed word.
    always @(posedge clk)
    begin : byte_checker
        rsp_word_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("response word with nothing owed", 0, rsp_word);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (rsp_word.out_byte !== want.out_byte)
                    report_mismatch("out_byte", want.out_byte, rsp_word.out_byte);
                if (rsp_word.last !== want.last)
                    report_mismatch("last", want.last, rsp_word.last);
                if (rsp_word.range_error !== want.range_error)
                    report_mismatch("range_error", want.range_error,
                                    rsp_word.range_error);
            end
        end
    end

    // Reads of the reset table, including the largest frame and both ends.
    task automatic test_preload_frames();
        send_word(read_req(8'h01, 8'h03, 16'd0, 16'd1));
        send_word(read_req(8'hFF, 8'hFF, 16'd0, 16'(MAX_REGS)));
        send_word(read_req(8'h00, 8'h00, 16'(TABLE_DEPTH - MAX_REGS), 16'(MAX_REGS)));
        send_word(read_req(8'hA5, 8'h5A, 16'(TABLE_DEPTH - 1), 16'd1));
        send_word(read_req(8'h11, 8'h03, 16'd10, 16'd3));
    endtask

    // Zero count, count above the limit and reads past the table end.
    task automatic test_range_errors();
        send_word(read_req(8'h01, 8'h03, 16'd0, 16'd0));
        send_word(read_req(8'h01, 8'h03, 16'd0, 16'(MAX_REGS + 1)));
        send_word(read_req(8'h02, 8'h03, 16'(TABLE_DEPTH - MAX_REGS + 1), 16'(MAX_REGS)));
        send_word(read_req(8'h03, 8'h03, 16'(TABLE_DEPTH), 16'd1));
        send_word(read_req(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_word(read_req(8'h04, 8'h04, 16'hFFFF, 16'd1));
        send_word(read_req(8'h05, 8'h06, 16'd5, 16'hFFFF));
    endtask

    // Loads at both ends and past the preload region, then read them back.
    task automatic test_table_loads();
        send_word(load_req(6'd0, 16'hFFFF));
        send_word(load_req(6'd63, 16'h0000));
        send_word(load_req(6'd50, 16'h1234));
        send_word(load_req(6'd63, 16'hABCD));
        send_word(read_req(8'h21, 8'h03, 16'd48, 16'd16));
        send_word(read_req(8'h22, 8'h03, 16'd0, 16'd1));
    endtask

    // Back-to-back traffic with no idling, a full drain, then one more read.
    task automatic test_drain_pause();
        no_idle = 1'b1;
        send_word(read_req(8'h31, 8'h03, 16'd20, 16'd5));
        send_word(load_req(6'd21, 16'h8001));
        hold_until_drained();
        send_word(read_req(8'h32, 8'h03, 16'd20, 16'd5));
        no_idle = 1'b0;
    endtask

    // Mostly well-formed reads with random content, plus loads and noise.
    task automatic test_random_traffic();
        int          kind;
        int          count;
        logic [15:0] first;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 35 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                hold_until_drained();
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_REGS)
                                                    : $urandom_range(1, 6);
                first = 16'($urandom_range(0, TABLE_DEPTH - count));
                send_word(read_req(8'($urandom()), 8'($urandom()), first,
                                   16'(count)));
            end
            else if (kind <= 7)
            begin
                send_word(load_req(6'($urandom()), 16'($urandom())));
            end
            else if (kind == 8)
            begin
                send_word(read_req(8'($urandom()), 8'($urandom()),
                                   16'($urandom()), 16'($urandom())));
            end
            else
            begin
                // Broken requests right at the edges of the legal range.
                case ($urandom_range(0, 2))
                    0: send_word(read_req(8'($urandom()), 8'($urandom()),
                                          16'($urandom_range(0, TABLE_DEPTH - 1)),
                                          16'd0));
                    1: send_word(read_req(8'($urandom()), 8'($urandom()),
                                          16'd0,
                                          16'($urandom_range(MAX_REGS + 1, 255))));
                    default:
                    begin
                        count = $urandom_range(1, MAX_REGS);
                        first = 16'(TABLE_DEPTH - count + $urandom_range(1, 8));
                        send_word(read_req(8'($urandom()), 8'($urandom()), first,
                                           16'(count)));
                    end
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            table_model[i] = (i < PRELOAD_COUNT) ? preload_words[i] : 16'h0000;

        // Single reset at the start of the run.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_preload_frames();
        test_range_errors();
        test_table_loads();
        test_drain_pause();
        test_random_traffic();

        // Stop sending, let every owed word arrive, then a short tail.
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_bytes.size() == 0)
            $display("tb_holding_register_read_responder passed");
        else
            $display("tb_holding_register_read_responder failed");
        $finish;
    end

endmodule
